// File: sv/csrh_pkg.sv
// shared types, constants and fixed-point helpers for the conic surface ray hit core
package csrh_pkg;

  localparam int IW      = 128;
  localparam int IFRAC   = 48;
  localparam int COORD_W = 48;
  localparam int COORD_F = 24;
  localparam int DIR_W   = 32;
  localparam int DIR_F   = 30;
  localparam int REG_W   = 48;
  localparam int CRV_F   = 40;
  localparam int KC_F    = 32;
  localparam int NRM_W   = 48;
  localparam int NRM_F   = 32;

  typedef logic signed [IW-1:0] iw_t;

  localparam iw_t I_ONE     = {{(IW-IFRAC-1){1'b0}}, 1'b1, {IFRAC{1'b0}}};
  localparam iw_t I_NEG_ONE = {{(IW-IFRAC){1'b1}}, {IFRAC{1'b0}}};
  localparam iw_t I_MAX     = {1'b0, {(IW-1){1'b1}}};
  localparam iw_t I_MIN     = {1'b1, {(IW-1){1'b0}}};

  localparam logic [1:0] SURF_CONIC = 2'd0;
  localparam logic [1:0] SURF_CYL   = 2'd1;
  localparam logic [1:0] SURF_PLANE = 2'd2;

  localparam logic [1:0] ST_HIT       = 2'd0;
  localparam logic [1:0] ST_MISS      = 2'd1;
  localparam logic [1:0] ST_NO_NORMAL = 2'd2;

  localparam logic [1:0] CFG_SURF = 2'd0;
  localparam logic [1:0] CFG_CRV  = 2'd1;
  localparam logic [1:0] CFG_KC   = 2'd2;
  localparam logic [1:0] CFG_NORM = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [DIR_W-1:0]   dir_l;
    logic signed [DIR_W-1:0]   dir_m;
    logic signed [DIR_W-1:0]   dir_n;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic signed [COORD_W-1:0] hit_z;
    logic signed [COORD_W-1:0] travel;
    logic signed [NRM_W-1:0]   normal_x;
    logic signed [NRM_W-1:0]   normal_y;
    logic signed [NRM_W-1:0]   normal_z;
    logic [1:0]                status;
  } out_word_t;

  typedef struct packed {
    iw_t  px;
    iw_t  py;
    iw_t  pz;
    iw_t  dl;
    iw_t  dm;
    iw_t  dn;
    iw_t  a0;
    iw_t  a1;
    iw_t  a2;
    iw_t  a3;
    iw_t  a4;
    iw_t  a5;
    iw_t  a6;
    logic hit;
    logic dneg;
    logic nbad;
    logic lenz;
  } ctx_t;

  function automatic iw_t sadd(iw_t a, iw_t b);
    logic [IW:0] s;
    s = {a[IW-1], a} + {b[IW-1], b};
    if (s[IW] != s[IW-1]) return s[IW] ? I_MIN : I_MAX;
    return iw_t'(s[IW-1:0]);
  endfunction

  function automatic iw_t snegsat(iw_t a);
    return (a == I_MIN) ? I_MAX : -a;
  endfunction

  function automatic iw_t ssub(iw_t a, iw_t b);
    return sadd(a, snegsat(b));
  endfunction

  function automatic logic [IW-1:0] iabs(iw_t a);
    return a[IW-1] ? IW'(-a) : IW'(a);
  endfunction

  function automatic iw_t coord_to_i(logic [COORD_W-1:0] x);
    return {{(IW-COORD_W-IFRAC+COORD_F){x[COORD_W-1]}}, x, {(IFRAC-COORD_F){1'b0}}};
  endfunction

  function automatic iw_t dir_to_i(logic [DIR_W-1:0] x);
    return {{(IW-DIR_W-IFRAC+DIR_F){x[DIR_W-1]}}, x, {(IFRAC-DIR_F){1'b0}}};
  endfunction

  function automatic iw_t crv_to_i(logic [REG_W-1:0] x);
    return {{(IW-REG_W-IFRAC+CRV_F){x[REG_W-1]}}, x, {(IFRAC-CRV_F){1'b0}}};
  endfunction

  function automatic iw_t kc_to_i(logic [REG_W-1:0] x);
    return {{(IW-REG_W-IFRAC+KC_F){x[REG_W-1]}}, x, {(IFRAC-KC_F){1'b0}}};
  endfunction

  // truncate toward zero by sh fraction bits, then saturate to 48 bits
  function automatic logic [COORD_W-1:0] narrow48(iw_t a, int unsigned sh);
    logic [IW-1:0] m;
    logic [IW-1:0] lim;
    logic          neg;
    neg = a[IW-1];
    m   = iabs(a) >> sh;
    lim = {{(IW-COORD_W){1'b0}}, neg, {(COORD_W-1){~neg}}};
    if (m > lim) m = lim;
    if (neg) m = -m;
    return m[COORD_W-1:0];
  endfunction

endpackage

// File: sv/csrh_mul.sv
// pipelined saturating fixed-point multiplier lanes built from 32x32 partial products
module csrh_mul #(
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [SW-1:0] in_side,
  input  csrh_pkg::iw_t in_a [LANES],
  input  csrh_pkg::iw_t in_b [LANES],
  output logic          out_valid,
  output logic [SW-1:0] out_side,
  output csrh_pkg::iw_t out_p [LANES]
);
  import csrh_pkg::*;

  localparam int DEPTH = 5;
  localparam int LIMBS = IW / 32;

  logic [DEPTH-1:0] v_r;
  logic [SW-1:0]    side_r [DEPTH];
  logic [IW-1:0]    ma_r   [LANES];
  logic [IW-1:0]    mb_r   [LANES];
  logic             neg_r  [LANES][DEPTH-1];
  logic [63:0]      pp_r   [LANES][LIMBS][LIMBS];
  logic [IW+63:0]   row_r  [LANES][LIMBS];
  logic [2*IW-1:0]  prod_r [LANES];
  iw_t              res_r  [LANES];

  function automatic logic [IW+63:0] rowsum(input logic [63:0] p [LIMBS]);
    logic [IW+63:0] acc;
    acc = '0;
    for (int j = 0; j < LIMBS; j++) acc = acc + ((IW+64)'(p[j]) << (32*j));
    return acc;
  endfunction

  function automatic logic [2*IW-1:0] prodsum(input logic [IW+63:0] r [LIMBS]);
    logic [2*IW-1:0] acc;
    acc = '0;
    for (int i = 0; i < LIMBS; i++) acc = acc + ((2*IW)'(r[i]) << (32*i));
    return acc;
  endfunction

  function automatic iw_t finish(logic [2*IW-1:0] p, logic neg);
    logic [2*IW-1:0] m;
    logic [IW-1:0]   mag;
    m   = p >> IFRAC;
    mag = (|m[2*IW-1:IW-1]) ? IW'(I_MAX) : m[IW-1:0];
    return neg ? -iw_t'(mag) : iw_t'(mag);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    for (int s = 1; s < DEPTH; s++) side_r[s] <= side_r[s-1];
    for (int l = 0; l < LANES; l++) begin
      ma_r[l]     <= iabs(in_a[l]);
      mb_r[l]     <= iabs(in_b[l]);
      neg_r[l][0] <= in_a[l][IW-1] ^ in_b[l][IW-1];
      for (int s = 1; s < DEPTH-1; s++) neg_r[l][s] <= neg_r[l][s-1];
      for (int i = 0; i < LIMBS; i++) begin
        for (int j = 0; j < LIMBS; j++) begin
          pp_r[l][i][j] <= 64'(ma_r[l][32*i +: 32]) * 64'(mb_r[l][32*j +: 32]);
        end
        row_r[l][i] <= rowsum(pp_r[l][i]);
      end
      prod_r[l] <= prodsum(row_r[l]);
      res_r[l]  <= finish(prod_r[l], neg_r[l][DEPTH-2]);
    end
  end

  assign out_valid = v_r[DEPTH-1];
  assign out_side  = side_r[DEPTH-1];
  assign out_p     = res_r;

endmodule

// File: sv/csrh_sqrt.sv
// pipelined digit-by-digit square root, two root bits per stage
module csrh_sqrt #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [SW-1:0] in_side,
  input  csrh_pkg::iw_t in_a,
  output logic          out_valid,
  output logic [SW-1:0] out_side,
  output csrh_pkg::iw_t out_root
);
  import csrh_pkg::*;

  localparam int RADW  = IW + IFRAC;
  localparam int ROOTW = RADW / 2;
  localparam int REMW  = ROOTW + 3;
  localparam int NST   = ROOTW / 2;
  localparam int DEPTH = NST + 1;

  typedef struct packed {
    logic [RADW-1:0]  rad;
    logic [REMW-1:0]  rem;
    logic [ROOTW-1:0] root;
  } sq_st_t;

  logic [DEPTH-1:0] v_r;
  logic [SW-1:0]    side_r [DEPTH];
  sq_st_t           st_r   [DEPTH];

  function automatic sq_st_t sq_step(sq_st_t st);
    sq_st_t        n;
    logic [REMW-1:0] rs;
    logic [REMW-1:0] trial;
    rs    = {st.rem[REMW-3:0], st.rad[RADW-1 -: 2]};
    trial = {1'b0, st.root, 2'b01};
    n.rad = st.rad << 2;
    if (rs >= trial) begin
      n.rem  = rs - trial;
      n.root = {st.root[ROOTW-2:0], 1'b1};
    end else begin
      n.rem  = rs;
      n.root = {st.root[ROOTW-2:0], 1'b0};
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0]    <= in_side;
    st_r[0].rad  <= {in_a, {IFRAC{1'b0}}};
    st_r[0].rem  <= '0;
    st_r[0].root <= '0;
    for (int s = 1; s < DEPTH; s++) begin
      side_r[s] <= side_r[s-1];
      st_r[s]   <= sq_step(sq_step(st_r[s-1]));
    end
  end

  assign out_valid = v_r[DEPTH-1];
  assign out_side  = side_r[DEPTH-1];
  assign out_root  = iw_t'({{(IW-ROOTW){1'b0}}, st_r[DEPTH-1].root});

endmodule

// File: sv/csrh_div.sv
// pipelined restoring divider lanes, two quotient bits per stage, saturating
module csrh_div #(
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [SW-1:0] in_side,
  input  csrh_pkg::iw_t in_num [LANES],
  input  csrh_pkg::iw_t in_den [LANES],
  output logic          out_valid,
  output logic [SW-1:0] out_side,
  output csrh_pkg::iw_t out_q [LANES]
);
  import csrh_pkg::*;

  localparam int NW    = IW + IFRAC;
  localparam int NST   = NW / 2;
  localparam int DEPTH = NST + 2;

  typedef struct packed {
    logic [NW-1:0] num;
    logic [IW:0]   rem;
    logic [NW-1:0] q;
    logic [IW-1:0] d;
    logic          neg;
  } dv_st_t;

  logic [DEPTH-1:0] v_r;
  logic [SW-1:0]    side_r [DEPTH];
  dv_st_t           st_r   [LANES][NST+1];
  iw_t              res_r  [LANES];

  function automatic dv_st_t dv_step(dv_st_t st);
    dv_st_t    n;
    logic [IW:0] rs;
    logic        qb;
    rs = {st.rem[IW-1:0], st.num[NW-1]};
    qb = (rs >= {1'b0, st.d});
    if (qb) rs = rs - {1'b0, st.d};
    n     = st;
    n.rem = rs;
    n.num = st.num << 1;
    n.q   = {st.q[NW-2:0], qb};
    return n;
  endfunction

  function automatic iw_t finish(dv_st_t st);
    logic [IW-1:0] mag;
    mag = (|st.q[NW-1:IW-1]) ? IW'(I_MAX) : {1'b0, st.q[IW-2:0]};
    return st.neg ? -iw_t'(mag) : iw_t'(mag);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    for (int s = 1; s < DEPTH; s++) side_r[s] <= side_r[s-1];
    for (int l = 0; l < LANES; l++) begin
      st_r[l][0].num <= {iabs(in_num[l]), {IFRAC{1'b0}}};
      st_r[l][0].rem <= '0;
      st_r[l][0].q   <= '0;
      st_r[l][0].d   <= iabs(in_den[l]);
      st_r[l][0].neg <= in_num[l][IW-1] ^ in_den[l][IW-1];
      for (int s = 1; s <= NST; s++) st_r[l][s] <= dv_step(dv_step(st_r[l][s-1]));
      res_r[l] <= finish(st_r[l][NST]);
    end
  end

  assign out_valid = v_r[DEPTH-1];
  assign out_side  = side_r[DEPTH-1];
  assign out_q     = res_r;

endmodule

// File: sv/conic_surface_ray_hit_core.sv
// top level: ray to conic, cylinder or plane intersection pipeline
//
// input channel: a ray word on in_word is taken at every clock edge with start
// high and busy low; busy stays low, so a new ray can enter every cycle.
// result channel: out_strobe is high for one cycle with the result word on
// out_word; there is no backpressure and the receiver must take it then.
// configuration: cfg_we writes cfg_data to register cfg_idx (surface type,
// curvature, conic constant, normalize flag); write only while no ray is in
// flight.
// from accept to strobe a ray goes through nine multiply passes, three square
// roots, three dividers and the output register. the dividers (two quotient
// bits per stage) set most of the depth.
// throughput: one ray per cycle.
// reset: clears all valid bits in flight and loads the register defaults
// (plane, zero curvature and conic constant, normalize on).
module conic_surface_ray_hit_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  csrh_pkg::in_word_t   in_word,
  output logic                 out_strobe,
  output csrh_pkg::out_word_t  out_word,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_idx,
  input  logic [47:0]          cfg_data
);
  import csrh_pkg::*;

  localparam int CW = $bits(ctx_t);

  logic [1:0]       surf_r;
  logic [REG_W-1:0] crv_r;
  logic [REG_W-1:0] kc_r;
  logic             nrm_r;
  iw_t              crv_i, kc_i, kp1;
  logic             curved, cyl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surf_r <= SURF_PLANE;
      crv_r  <= '0;
      kc_r   <= '0;
      nrm_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SURF: surf_r <= cfg_data[1:0];
        CFG_CRV:  crv_r  <= cfg_data;
        CFG_KC:   kc_r   <= cfg_data;
        CFG_NORM: nrm_r  <= cfg_data[0];
        default:  nrm_r  <= nrm_r;
      endcase
    end
  end

  assign crv_i  = crv_to_i(crv_r);
  assign kc_i   = kc_to_i(kc_r);
  assign kp1    = sadd(I_ONE, kc_i);
  assign curved = (surf_r == SURF_CONIC) || (surf_r == SURF_CYL);
  assign cyl    = (surf_r == SURF_CYL);
  assign busy   = 1'b0;

  ctx_t c1i, c1o, c2i, c2o, c3i, c3o, c4i, c4o, s1i, s1o, d1i, d1o;
  ctx_t c6i, c6o, c7i, c7o, c8i, c8o, c9i, c9o, s2i, s2o, d2i, d2o;
  ctx_t c11i, c11o, s3i, s3o, d3i, d3o;
  logic v1o, v2o, v3o, v4o, vs1o, vd1o, v6o, v7o, v8o, v9o, vs2o, vd2o, v11o, vs3o, vd3o;

  iw_t a1 [7], b1 [7], p1 [7];
  iw_t a2 [3], b2 [3], p2 [3];
  iw_t a3 [3], b3 [3], p3 [3];
  iw_t a4 [2], b4 [2], p4 [2];
  iw_t sq1_in, sq1_out;
  iw_t n1 [1], e1 [1], q1 [1];
  iw_t a6 [3], b6 [3], p6 [3];
  iw_t a7 [5], b7 [5], p7 [5];
  iw_t a8 [1], b8 [1], p8 [1];
  iw_t a9 [1], b9 [1], p9 [1];
  iw_t sq2_in, sq2_out;
  iw_t n2 [2], e2 [2], q2 [2];
  iw_t a11 [2], b11 [2], p11 [2];
  iw_t sq3_in, sq3_out;
  iw_t n3 [3], e3 [3], q3 [3];

  always_comb begin
    c1i    = '0;
    c1i.px = coord_to_i(in_word.start_x);
    c1i.py = coord_to_i(in_word.start_y);
    c1i.pz = coord_to_i(in_word.start_z);
    c1i.dl = dir_to_i(in_word.dir_l);
    c1i.dm = dir_to_i(in_word.dir_m);
    c1i.dn = dir_to_i(in_word.dir_n);
    a1[0] = c1i.px; b1[0] = c1i.px;
    a1[1] = c1i.pz; b1[1] = c1i.pz;
    a1[2] = c1i.py; b1[2] = c1i.py;
    a1[3] = c1i.px; b1[3] = c1i.dl;
    a1[4] = c1i.pz; b1[4] = c1i.dn;
    a1[5] = c1i.py; b1[5] = c1i.dm;
    a1[6] = c1i.dn; b1[6] = c1i.dn;
  end

  csrh_mul #(.LANES(7), .SW(CW)) u_mul1 (
    .clk, .rst_n, .in_valid(start & ~busy), .in_side(c1i), .in_a(a1), .in_b(b1),
    .out_valid(v1o), .out_side(c1o), .out_p(p1));

  always_comb begin
    c2i    = c1o;
    c2i.a0 = p1[0];
    c2i.a1 = p1[2];
    c2i.a2 = p1[3];
    c2i.a3 = p1[5];
    a2[0] = kp1;  b2[0] = p1[1];
    a2[1] = kp1;  b2[1] = p1[4];
    a2[2] = kc_i; b2[2] = p1[6];
  end

  csrh_mul #(.LANES(3), .SW(CW)) u_mul2 (
    .clk, .rst_n, .in_valid(v1o), .in_side(c2i), .in_a(a2), .in_b(b2),
    .out_valid(v2o), .out_side(c2o), .out_p(p2));

  iw_t sq_sum, dot_sum, qa;

  always_comb begin
    sq_sum  = sadd(c2o.a0, p2[0]);
    dot_sum = sadd(c2o.a2, p2[1]);
    if (!cyl) begin
      sq_sum  = sadd(sq_sum, c2o.a1);
      dot_sum = sadd(dot_sum, c2o.a3);
    end
    qa  = sadd(I_ONE, p2[2]);
    c3i = c2o;
    a3[0] = crv_i; b3[0] = dot_sum;
    a3[1] = crv_i; b3[1] = sq_sum;
    a3[2] = crv_i; b3[2] = qa;
  end

  csrh_mul #(.LANES(3), .SW(CW)) u_mul3 (
    .clk, .rst_n, .in_valid(v2o), .in_side(c3i), .in_a(a3), .in_b(b3),
    .out_valid(v3o), .out_side(c3o), .out_p(p3));

  always_comb begin
    c4i    = c3o;
    c4i.a0 = ssub(p3[0], c3o.dn);
    c4i.a1 = ssub(p3[1], sadd(c3o.pz, c3o.pz));
    a4[0] = c4i.a0; b4[0] = c4i.a0;
    a4[1] = p3[2];  b4[1] = c4i.a1;
  end

  csrh_mul #(.LANES(2), .SW(CW)) u_mul4 (
    .clk, .rst_n, .in_valid(v3o), .in_side(c4i), .in_a(a4), .in_b(b4),
    .out_valid(v4o), .out_side(c4o), .out_p(p4));

  always_comb begin
    sq1_in   = ssub(p4[0], p4[1]);
    s1i      = c4o;
    s1i.dneg = sq1_in[IW-1];
  end

  csrh_sqrt #(.SW(CW)) u_sqrt1 (
    .clk, .rst_n, .in_valid(v4o), .in_side(s1i), .in_a(sq1_in),
    .out_valid(vs1o), .out_side(s1o), .out_root(sq1_out));

  iw_t den_c;

  always_comb begin
    den_c = ssub(sq1_out, s1o.a0);
    d1i   = s1o;
    if (curved) begin
      n1[0]   = s1o.a1;
      e1[0]   = den_c;
      d1i.hit = !s1o.dneg && (den_c != '0);
    end else begin
      n1[0]   = snegsat(s1o.pz);
      e1[0]   = s1o.dn;
      d1i.hit = (s1o.dn != '0);
    end
  end

  csrh_div #(.LANES(1), .SW(CW)) u_div1 (
    .clk, .rst_n, .in_valid(vs1o), .in_side(d1i), .in_num(n1), .in_den(e1),
    .out_valid(vd1o), .out_side(d1o), .out_q(q1));

  always_comb begin
    c6i    = d1o;
    c6i.a0 = q1[0];
    a6[0] = q1[0]; b6[0] = d1o.dl;
    a6[1] = q1[0]; b6[1] = d1o.dm;
    a6[2] = q1[0]; b6[2] = d1o.dn;
  end

  csrh_mul #(.LANES(3), .SW(CW)) u_mul6 (
    .clk, .rst_n, .in_valid(vd1o), .in_side(c6i), .in_a(a6), .in_b(b6),
    .out_valid(v6o), .out_side(c6o), .out_p(p6));

  always_comb begin
    c7i    = c6o;
    c7i.a1 = sadd(c6o.px, p6[0]);
    c7i.a2 = sadd(c6o.py, p6[1]);
    c7i.a3 = sadd(c6o.pz, p6[2]);
    a7[0] = c7i.a1; b7[0] = c7i.a1;
    a7[1] = c7i.a2; b7[1] = c7i.a2;
    a7[2] = crv_i;  b7[2] = crv_i;
    a7[3] = crv_i;  b7[3] = c7i.a1;
    a7[4] = crv_i;  b7[4] = c7i.a2;
  end

  csrh_mul #(.LANES(5), .SW(CW)) u_mul7 (
    .clk, .rst_n, .in_valid(v6o), .in_side(c7i), .in_a(a7), .in_b(b7),
    .out_valid(v7o), .out_side(c7o), .out_p(p7));

  always_comb begin
    c8i    = c7o;
    c8i.a4 = p7[3];
    c8i.a5 = p7[4];
    c8i.a6 = cyl ? p7[0] : sadd(p7[0], p7[1]);
    a8[0] = p7[2];
    b8[0] = kp1;
  end

  csrh_mul #(.LANES(1), .SW(CW)) u_mul8 (
    .clk, .rst_n, .in_valid(v7o), .in_side(c8i), .in_a(a8), .in_b(b8),
    .out_valid(v8o), .out_side(c8o), .out_p(p8));

  always_comb begin
    c9i   = c8o;
    a9[0] = p8[0];
    b9[0] = c8o.a6;
  end

  csrh_mul #(.LANES(1), .SW(CW)) u_mul9 (
    .clk, .rst_n, .in_valid(v8o), .in_side(c9i), .in_a(a9), .in_b(b9),
    .out_valid(v9o), .out_side(c9o), .out_p(p9));

  always_comb begin
    sq2_in   = ssub(I_ONE, p9[0]);
    s2i      = c9o;
    s2i.nbad = sq2_in[IW-1] || (sq2_in == '0);
  end

  csrh_sqrt #(.SW(CW)) u_sqrt2 (
    .clk, .rst_n, .in_valid(v9o), .in_side(s2i), .in_a(sq2_in),
    .out_valid(vs2o), .out_side(s2o), .out_root(sq2_out));

  always_comb begin
    d2i      = s2o;
    d2i.nbad = s2o.nbad || (sq2_out == '0);
    n2[0] = s2o.a4; e2[0] = sq2_out;
    n2[1] = s2o.a5; e2[1] = sq2_out;
  end

  csrh_div #(.LANES(2), .SW(CW)) u_div2 (
    .clk, .rst_n, .in_valid(vs2o), .in_side(d2i), .in_num(n2), .in_den(e2),
    .out_valid(vd2o), .out_side(d2o), .out_q(q2));

  always_comb begin
    c11i    = d2o;
    c11i.a4 = q2[0];
    c11i.a5 = cyl ? '0 : q2[1];
    a11[0] = c11i.a4; b11[0] = c11i.a4;
    a11[1] = c11i.a5; b11[1] = c11i.a5;
  end

  csrh_mul #(.LANES(2), .SW(CW)) u_mul11 (
    .clk, .rst_n, .in_valid(vd2o), .in_side(c11i), .in_a(a11), .in_b(b11),
    .out_valid(v11o), .out_side(c11o), .out_p(p11));

  always_comb begin
    sq3_in = sadd(sadd(p11[0], p11[1]), I_ONE);
    s3i    = c11o;
  end

  csrh_sqrt #(.SW(CW)) u_sqrt3 (
    .clk, .rst_n, .in_valid(v11o), .in_side(s3i), .in_a(sq3_in),
    .out_valid(vs3o), .out_side(s3o), .out_root(sq3_out));

  always_comb begin
    d3i      = s3o;
    d3i.lenz = (sq3_out == '0);
    n3[0] = s3o.a4;    e3[0] = sq3_out;
    n3[1] = s3o.a5;    e3[1] = sq3_out;
    n3[2] = I_NEG_ONE; e3[2] = sq3_out;
  end

  csrh_div #(.LANES(3), .SW(CW)) u_div3 (
    .clk, .rst_n, .in_valid(vs3o), .in_side(d3i), .in_num(n3), .in_den(e3),
    .out_valid(vd3o), .out_side(d3o), .out_q(q3));

  out_word_t out_word_nxt, out_word_r;
  logic      out_strobe_r;
  iw_t       nx, ny, nz;

  always_comb begin
    nx = '0;
    ny = '0;
    nz = '0;
    out_word_nxt = '0;
    if (!d3o.hit) begin
      out_word_nxt.status = ST_MISS;
    end else begin
      out_word_nxt.status = ST_HIT;
      if (!curved) begin
        nz = I_NEG_ONE;
      end else if (d3o.nbad) begin
        out_word_nxt.status = ST_NO_NORMAL;
      end else if (nrm_r && !d3o.lenz) begin
        nx = q3[0];
        ny = q3[1];
        nz = q3[2];
      end else begin
        nx = d3o.a4;
        ny = d3o.a5;
        nz = I_NEG_ONE;
      end
      out_word_nxt.hit_x    = narrow48(d3o.a1, IFRAC - COORD_F);
      out_word_nxt.hit_y    = narrow48(d3o.a2, IFRAC - COORD_F);
      out_word_nxt.hit_z    = narrow48(d3o.a3, IFRAC - COORD_F);
      out_word_nxt.travel   = narrow48(d3o.a0, IFRAC - COORD_F);
      out_word_nxt.normal_x = narrow48(nx, IFRAC - NRM_F);
      out_word_nxt.normal_y = narrow48(ny, IFRAC - NRM_F);
      out_word_nxt.normal_z = narrow48(nz, IFRAC - NRM_F);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= vd3o;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

// File: test/conic_surface_ray_hit_checker.sv
// checker for the conic surface ray hit core: fixed-point hit prediction and word compare
`timescale 1ns / 1ps

module conic_surface_ray_hit_checker
  import csrh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  in_word_t   in_word,
  input  logic       out_strobe,
  input  out_word_t  out_word,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [47:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output int         hit_count,
  output int         miss_count,
  output int         no_normal_count
);

  typedef logic signed [127:0] fx_t;

  localparam fx_t FX_ONE = fx_t'(1) <<< 48;
  localparam fx_t FX_MAX = {1'b0, {127{1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {127{1'b0}}};

  logic [1:0]  surf_kind;
  logic [47:0] curv_reg;
  logic [47:0] conic_k_reg;
  logic        unit_normal;

  out_word_t expected_hits[$];

  function automatic fx_t fx_add(fx_t a, fx_t b);
    logic signed [128:0] s;
    s = a;
    s = s + b;
    if (s > FX_MAX) return FX_MAX;
    if (s < FX_MIN) return FX_MIN;
    return s[127:0];
  endfunction

  function automatic fx_t fx_neg(fx_t a);
    return (a == FX_MIN) ? FX_MAX : -a;
  endfunction

  function automatic fx_t fx_sub(fx_t a, fx_t b);
    return fx_add(a, fx_neg(b));
  endfunction

  function automatic logic [127:0] fx_mag(fx_t a);
    return a[127] ? 128'(-a) : 128'(a);
  endfunction

  function automatic fx_t fx_signed(logic [255:0] m, logic neg);
    fx_t v;
    if (m > 256'(FX_MAX)) m = 256'(FX_MAX);
    v = m[127:0];
    return neg ? -v : v;
  endfunction

  function automatic fx_t fx_mul(fx_t a, fx_t b);
    logic [255:0] p;
    p = 256'(fx_mag(a)) * 256'(fx_mag(b));
    return fx_signed(p >> 48, a[127] ^ b[127]);
  endfunction

  function automatic fx_t fx_div(fx_t a, fx_t b);
    logic [255:0] n;
    n = 256'(fx_mag(a)) << 48;
    return fx_signed(n / 256'(fx_mag(b)), a[127] ^ b[127]);
  endfunction

  function automatic fx_t fx_sqrt(fx_t a);
    logic [255:0] u;
    logic [255:0] r;
    logic [255:0] c;
    u = 256'(fx_mag(a)) << 48;
    r = '0;
    for (int b = 88; b >= 0; b--) begin
      c = r | (256'(1) << b);
      if (c * c <= u) r = c;
    end
    return fx_t'(r[127:0]);
  endfunction

  function automatic logic [47:0] fx_narrow(fx_t a, int sh);
    logic [127:0] m;
    logic [127:0] lim;
    logic         neg;
    neg = a[127];
    m = fx_mag(a) >> sh;
    lim = neg ? (128'(1) << 47) : ((128'(1) << 47) - 1);
    if (m > lim) m = lim;
    if (neg) m = -m;
    return m[47:0];
  endfunction

  function automatic out_word_t trace_ray(in_word_t w);
    fx_t px, py, pz, dl, dm, dn, crv, kc, kp1;
    fx_t travel_d, nx, ny, nz, hx, hy, hz;
    fx_t sq, dot, qa, qb, qc, disc, den, r2, q, root, len;
    logic curved, cyl, hit;
    out_word_t r;
    px = fx_t'($signed(w.start_x)) <<< 24;
    py = fx_t'($signed(w.start_y)) <<< 24;
    pz = fx_t'($signed(w.start_z)) <<< 24;
    dl = fx_t'($signed(w.dir_l)) <<< 18;
    dm = fx_t'($signed(w.dir_m)) <<< 18;
    dn = fx_t'($signed(w.dir_n)) <<< 18;
    crv = fx_t'($signed(curv_reg)) <<< 8;
    kc = fx_t'($signed(conic_k_reg)) <<< 16;
    kp1 = fx_add(FX_ONE, kc);
    travel_d = '0; nx = '0; ny = '0; nz = '0;
    curved = (surf_kind == SURF_CONIC) || (surf_kind == SURF_CYL);
    cyl = (surf_kind == SURF_CYL);
    hit = 1'b0;
    r = '0;
    if (curved) begin
      sq = fx_add(fx_mul(px, px), fx_mul(kp1, fx_mul(pz, pz)));
      dot = fx_add(fx_mul(px, dl), fx_mul(kp1, fx_mul(pz, dn)));
      if (!cyl) begin
        sq = fx_add(sq, fx_mul(py, py));
        dot = fx_add(dot, fx_mul(py, dm));
      end
      qa = fx_add(FX_ONE, fx_mul(kc, fx_mul(dn, dn)));
      qb = fx_sub(fx_mul(crv, dot), dn);
      qc = fx_sub(fx_mul(crv, sq), fx_add(pz, pz));
      disc = fx_sub(fx_mul(qb, qb), fx_mul(fx_mul(crv, qa), qc));
      if (!disc[127]) begin
        den = fx_sub(fx_sqrt(disc), qb);
        if (den != 0) begin
          travel_d = fx_div(qc, den);
          hit = 1'b1;
        end
      end
    end else if (dn != 0) begin
      travel_d = fx_div(fx_neg(pz), dn);
      hit = 1'b1;
    end
    if (!hit) begin
      r.status = ST_MISS;
      return r;
    end
    hx = fx_add(px, fx_mul(travel_d, dl));
    hy = fx_add(py, fx_mul(travel_d, dm));
    hz = fx_add(pz, fx_mul(travel_d, dn));
    r.status = ST_HIT;
    if (!curved) begin
      nz = -FX_ONE;
    end else begin
      r2 = fx_mul(hx, hx);
      if (!cyl) r2 = fx_add(r2, fx_mul(hy, hy));
      q = fx_sub(FX_ONE, fx_mul(fx_mul(fx_mul(crv, crv), kp1), r2));
      root = (q[127] || q == 0) ? fx_t'(0) : fx_sqrt(q);
      if (root == 0) begin
        r.status = ST_NO_NORMAL;
      end else begin
        nx = fx_div(fx_mul(crv, hx), root);
        ny = cyl ? fx_t'(0) : fx_div(fx_mul(crv, hy), root);
        nz = -FX_ONE;
        if (unit_normal) begin
          len = fx_sqrt(fx_add(fx_add(fx_mul(nx, nx), fx_mul(ny, ny)), FX_ONE));
          if (len != 0) begin
            nx = fx_div(nx, len);
            ny = fx_div(ny, len);
            nz = fx_div(nz, len);
          end
        end
      end
    end
    r.hit_x = fx_narrow(hx, 24);
    r.hit_y = fx_narrow(hy, 24);
    r.hit_z = fx_narrow(hz, 24);
    r.travel = fx_narrow(travel_d, 24);
    r.normal_x = fx_narrow(nx, 16);
    r.normal_y = fx_narrow(ny, 16);
    r.normal_z = fx_narrow(nz, 16);
    return r;
  endfunction

  task automatic check_field(string name, logic [47:0] exp_v, logic [47:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    hit_count = 0;
    miss_count = 0;
    no_normal_count = 0;
  end

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      surf_kind <= SURF_PLANE;
      curv_reg <= '0;
      conic_k_reg <= '0;
      unit_normal <= 1'b1;
      expected_hits.delete();
    end else begin
      if (start && !busy) expected_hits.push_back(trace_ray(in_word));
      if (out_strobe) begin
        if (expected_hits.size() == 0) begin
          $error("result word with no ray outstanding");
          fail_count++;
        end else begin
          e = expected_hits.pop_front();
          check_field("hit_x", e.hit_x, out_word.hit_x);
          check_field("hit_y", e.hit_y, out_word.hit_y);
          check_field("hit_z", e.hit_z, out_word.hit_z);
          check_field("travel", e.travel, out_word.travel);
          check_field("normal_x", e.normal_x, out_word.normal_x);
          check_field("normal_y", e.normal_y, out_word.normal_y);
          check_field("normal_z", e.normal_z, out_word.normal_z);
          check_field("status", 48'(e.status), 48'(out_word.status));
          case (e.status)
            ST_HIT:  hit_count++;
            ST_MISS: miss_count++;
            default: no_normal_count++;
          endcase
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_SURF: surf_kind <= cfg_data[1:0];
          CFG_CRV:  curv_reg <= cfg_data;
          CFG_KC:   conic_k_reg <= cfg_data;
          default:  unit_normal <= cfg_data[0];
        endcase
      end
    end
    pending <= expected_hits.size();
  end

endmodule

// File: test/conic_surface_ray_hit_core_tb.sv
// testbench top for the conic surface ray hit core: ray stimulus, surface settings, verdict
`timescale 1ns / 1ps

module conic_surface_ray_hit_core_tb;
  import csrh_pkg::*;

  localparam longint     U = 64'sd1 <<< 24;
  localparam int         D = 1 << 30;
  localparam longint     C_ONE = 64'sd1 <<< 40;
  localparam longint     K_ONE = 64'sd1 <<< 32;
  localparam logic [1:0] SURF_ALIAS = 2'd3;
  localparam int         IDLE_LIMIT = 5000;
  localparam int         TAIL = 460;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_word_t   in_word = '0;
  logic       out_strobe;
  out_word_t  out_word;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_idx = CFG_SURF;
  logic [47:0] cfg_data = '0;

  int fail_count, pending, hit_count, miss_count, no_normal_count;
  int rays_sent = 0;
  int settings_used = 0;
  int idle_cycles = 0;
  bit dense = 1'b0;

  always #2 clk = ~clk;

  conic_surface_ray_hit_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  conic_surface_ray_hit_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .hit_count(hit_count),
    .miss_count(miss_count), .no_normal_count(no_normal_count)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic longint rnd_sym(int unsigned span);
    return longint'($urandom_range(0, 2 * span)) - longint'(span);
  endfunction

  function automatic int rnd_dir();
    return int'($urandom_range(0, 32'h8000_0000)) - D;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (dense || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_word_t make_ray(longint x, longint y, longint z, int l, int m, int n);
    in_word_t w;
    w.start_x = x[47:0];
    w.start_y = y[47:0];
    w.start_z = z[47:0];
    w.dir_l = l;
    w.dir_m = m;
    w.dir_n = n;
    return w;
  endfunction

  function automatic in_word_t random_ray();
    int span;
    int nz;
    if ($urandom_range(0, 99) < 20) begin
      return make_ray({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      rnd_dir(), rnd_dir(), rnd_dir());
    end
    span = ($urandom_range(0, 9) == 0) ? 30 * 32'h0100_0000 : 2 * 32'h0100_0000;
    nz = ($urandom_range(0, 9) == 0) ? -int'($urandom_range(0, D))
                                     : int'($urandom_range(D / 2, D));
    return make_ray(rnd_sym(span), rnd_sym(span), -longint'($urandom_range(0, 5 * U)),
                    int'(rnd_sym(D / 3)), int'(rnd_sym(D / 3)), nz);
  endfunction

  task automatic send_ray(in_word_t w);
    int g;
    bit ok;
    g = pick_gap();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_word <= w;
    start <= 1'b1;
    forever begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
      if (ok) break;
    end
    rays_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic load_surface(logic [1:0] kind, longint c, longint k, logic nrm);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_SURF;
    cfg_data <= 48'(kind);
    @(posedge clk);
    cfg_idx <= CFG_CRV;
    cfg_data <= c[47:0];
    @(posedge clk);
    cfg_idx <= CFG_KC;
    cfg_data <= k[47:0];
    @(posedge clk);
    cfg_idx <= CFG_NORM;
    cfg_data <= 48'(nrm);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic random_phase(int count);
    dense = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) send_ray(random_ray());
    dense = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // plane at reset defaults
    send_ray(make_ray(0, 0, -U, 0, 0, D));
    send_ray(make_ray(3 * U, -U, -2 * U, D / 4, D / 8, 0));
    send_ray(make_ray(0, 0, 5 * U, 0, 0, -D));
    send_ray(make_ray(48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF, D, -D, 1));
    send_ray(make_ray(-(64'sd1 <<< 47), -(64'sd1 <<< 47), -(64'sd1 <<< 47), -D, -D, -D));
    send_ray(make_ray(-1, 1, -(64'sd1 <<< 47), 1, -1, D));

    // shallow conic: on-axis, off-axis, backward ray
    load_surface(SURF_CONIC, C_ONE / 50, 0, 1'b1);
    send_ray(make_ray(0, 0, -U, 0, 0, D));
    send_ray(make_ray(3 * U, -2 * U, -4 * U, D / 10, -D / 10, D - D / 100));
    send_ray(make_ray(U, U, -U, 0, 0, -D));

    // oblate unit sphere: grazing rim gives undefined normal, far ray misses
    load_surface(SURF_CONIC, C_ONE, 3 * K_ONE, 1'b1);
    send_ray(make_ray(U / 2, 0, -U, 0, 0, D));
    send_ray(make_ray(U / 2 - 1, 0, -U, 0, 0, D));
    send_ray(make_ray(U / 2 + U / 100, 0, -U, 0, 0, D));
    send_ray(make_ray(5 * U, 0, -U, 0, 0, D));

    // zero curvature behaves as a plane only for forward rays
    load_surface(SURF_CONIC, 0, 0, 1'b0);
    send_ray(make_ray(U, 2 * U, -3 * U, D / 5, 0, D / 2));
    send_ray(make_ray(U, 2 * U, -3 * U, D / 5, 0, -D / 2));
    send_ray(make_ray(U, 2 * U, -3 * U, D, 0, 0));

    // cylinder, y ignored in the quadratic
    load_surface(SURF_CYL, C_ONE / 5, 0, 1'b0);
    send_ray(make_ray(U, 7 * U, -2 * U, D / 7, D / 3, D - D / 10));
    send_ray(make_ray(20 * U, 0, -U, 0, 0, D));
    load_surface(SURF_CYL, -C_ONE / 3, K_ONE / 2, 1'b1);
    send_ray(make_ray(-U / 2, U, -U, 0, D / 2, D - D / 8));

    // unused surface code falls back to the plane
    load_surface(SURF_ALIAS, C_ONE, K_ONE, 1'b1);
    send_ray(make_ray(U, U, -2 * U, 0, 0, D));
    send_ray(make_ray(U, U, -2 * U, D, 0, 0));

    load_surface(SURF_CONIC, C_ONE / 50, 0, 1'b1);
    random_phase(45);
    load_surface(SURF_CONIC, -C_ONE / 20, -K_ONE, 1'b0);
    random_phase(45);
    load_surface(SURF_CONIC, C_ONE, 3 * K_ONE, 1'b1);
    random_phase(45);
    load_surface(SURF_CYL, C_ONE / 10, 0, 1'b1);
    random_phase(45);
    load_surface(SURF_CYL, -C_ONE * 3 / 10, K_ONE / 2, 1'b0);
    random_phase(40);
    load_surface(SURF_CONIC, 48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF, 1'b1);
    random_phase(40);
    load_surface(SURF_CONIC, -(64'sd1 <<< 47), -(64'sd1 <<< 47), 1'b0);
    random_phase(40);
    load_surface(SURF_CONIC, 0, 0, 1'b1);
    random_phase(35);
    load_surface(SURF_PLANE, 0, 0, 1'b0);
    random_phase(35);
    load_surface(SURF_ALIAS, C_ONE / 4, K_ONE, 1'b0);
    random_phase(30);
    load_surface(SURF_CONIC, {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom));
    random_phase(35);
    load_surface(SURF_CYL, {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom));
    random_phase(35);
    load_surface(SURF_CONIC, rnd_sym(32'h4000_0000) * 4, rnd_sym(32'h4000_0000) * 12, 1'b1);
    random_phase(45);

    drain();
    repeat (TAIL) @(posedge clk);
    $display("sent %0d rays over %0d surface settings", rays_sent, settings_used);
    $display("results: %0d hits, %0d misses, %0d without normal",
             hit_count, miss_count, no_normal_count);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
sv/csrh_pkg.sv
sv/csrh_mul.sv
sv/csrh_sqrt.sv
sv/csrh_div.sv
sv/conic_surface_ray_hit_core.sv
test/conic_surface_ray_hit_checker.sv
test/conic_surface_ray_hit_core_tb.sv
